>>> rtl/core/clnw_pkg.sv
// ----------------------------------------------------------------------------
// clnw_pkg
// Shared types, codes and the Cyrillic code-page table of the LCD nibble
// writer.
// ----------------------------------------------------------------------------
package clnw_pkg;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned NibbleW  = 4;
  localparam int unsigned WaitW    = 13;
  localparam int unsigned ShortW   = 8;
  localparam int unsigned ExtraW   = 12;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  typedef enum logic [ActionW-1:0] {
    ACT_CTRL_BYTE   = 2'd0,
    ACT_DATA_BYTE   = 2'd1,
    ACT_TEXT        = 2'd2,
    ACT_CTRL_NIBBLE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LEAD_OTHER = 2'd0,
    LEAD_D0    = 2'd1,
    LEAD_D1    = 2'd2,
    LEAD_C2    = 2'd3
  } lead_e;

  typedef enum logic [1:0] {
    PH_RS   = 2'd0,
    PH_EN   = 2'd1,
    PH_DATA = 2'd2,
    PH_HOLD = 2'd3
  } phase_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RS_SETUP  = 3'd0,
    CFG_EN_SETUP  = 3'd1,
    CFG_DATA      = 3'd2,
    CFG_HOLD      = 3'd3,
    CFG_CTRL_XTRA = 3'd4
  } cfg_idx_e;

  // One write command handed from the front end to the phase sequencer.
  typedef struct packed {
    logic             rs;      // 1 data, 0 control
    logic             single;  // low nibble only
    logic [ByteW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [ShortW-1:0] rs_setup;
    logic [ShortW-1:0] en_setup;
    logic [ShortW-1:0] data;
    logic [ShortW-1:0] hold;
    logic [ExtraW-1:0] ctrl_extra;
  } cfg_t;

  localparam logic [ByteW-1:0] LeadD0     = 8'hd0;
  localparam logic [ByteW-1:0] LeadD1     = 8'hd1;
  localparam logic [ByteW-1:0] LeadC2     = 8'hc2;
  localparam logic [ByteW-1:0] OffsetD0   = 8'h90;
  localparam logic [ByteW-1:0] OffsetD1   = 8'h50;
  localparam logic [ByteW-1:0] TrailIoSm  = 8'h91;
  localparam logic [ByteW-1:0] TrailIoCap = 8'h81;
  localparam logic [ByteW-1:0] TrailDeg   = 8'hb0;
  localparam logic [ByteW-1:0] CodeIoSm   = 8'hb5;
  localparam logic [ByteW-1:0] CodeIoCap  = 8'ha2;
  localparam logic [ByteW-1:0] CodeDeg    = 8'hef;

  localparam cfg_t CfgReset = '{
    rs_setup:   8'd1,
    en_setup:   8'd1,
    data:       8'd20,
    hold:       8'd20,
    ctrl_extra: 12'h7ff
  };

  localparam logic [ByteW-1:0] CyrRom [64] = '{
    8'h41, 8'ha0, 8'h42, 8'ha1, 8'he0, 8'h45, 8'ha3, 8'ha4,
    8'ha5, 8'ha6, 8'h4b, 8'ha7, 8'h4d, 8'h48, 8'h4f, 8'ha8,
    8'h50, 8'h43, 8'h54, 8'ha9, 8'haa, 8'h58, 8'he1, 8'hab,
    8'hac, 8'he2, 8'had, 8'hae, 8'h62, 8'haf, 8'hb0, 8'hb1,
    8'h61, 8'hb2, 8'hb3, 8'hb4, 8'he3, 8'h65, 8'hb6, 8'hb7,
    8'hb8, 8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'h6f, 8'hbe,
    8'h70, 8'h63, 8'hbf, 8'h79, 8'he4, 8'h78, 8'he5, 8'hc0,
    8'hc1, 8'he6, 8'hc2, 8'hc3, 8'hc4, 8'hc5, 8'hc6, 8'hc7
  };

  function automatic lead_e lead_kind(logic [ByteW-1:0] b);
    lead_e k;
    k = LEAD_OTHER;
    if (b == LeadD0) k = LEAD_D0;
    else if (b == LeadD1) k = LEAD_D1;
    else if (b == LeadC2) k = LEAD_C2;
    return k;
  endfunction

  // Map a trail byte to the display code page; out-of-table bytes pass.
  function automatic logic [ByteW-1:0] cyr_translate(lead_e kind, logic [ByteW-1:0] b);
    logic [ByteW-1:0] shift;
    logic [ByteW:0]   diff;
    logic [ByteW-1:0] res;
    shift = (kind == LEAD_D0) ? OffsetD0 : (kind == LEAD_D1) ? OffsetD1 : '0;
    diff  = {1'b0, b} - {1'b0, shift};
    res   = b;
    if (diff[ByteW:6] == '0) res = CyrRom[diff[5:0]];
    if (b == TrailIoSm && kind == LEAD_D1) res = CodeIoSm;
    if (b == TrailIoCap && kind == LEAD_D0) res = CodeIoCap;
    if (b == TrailDeg && kind == LEAD_C2) res = CodeDeg;
    return res;
  endfunction

endpackage

>>> rtl/core/clnw_if.sv
// ----------------------------------------------------------------------------
// clnw_if
// Valid/ready channels of the LCD nibble writer: input items, pin phases
// and register writes.
// ----------------------------------------------------------------------------
interface clnw_in_if import clnw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ActionW-1:0] action;
  logic [ByteW-1:0]   byte_value;

  modport source (output valid, action, byte_value, input ready);
  modport sink   (input valid, action, byte_value, output ready);
endinterface

interface clnw_out_if import clnw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               reg_select;
  logic               enable;
  logic [NibbleW-1:0] nibble;
  logic [WaitW-1:0]   wait_units;
  logic               last;

  modport source (output valid, reg_select, enable, nibble, wait_units, last,
                  input ready);
  modport sink   (input valid, reg_select, enable, nibble, wait_units, last,
                  output ready);
endinterface

interface clnw_cfg_if import clnw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/char_lcd_nibble_writer_cyrillic_top.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_cyrillic_top
// Character LCD 4-bit bus writer with UTF-8 Cyrillic text translation.
// ----------------------------------------------------------------------------
// Each accepted item (control byte, data byte, text byte or single control
// nibble) becomes a stream of pin phases on out_o: four phases per nibble
// (register select, enable high, nibble driven, enable low), high nibble
// first, each with its wait count; last marks the final phase of the item.
// A byte gives eight phases and a single nibble four, produced at one phase
// per clock by the phase sequencer while out_o is not stalled. A text lead
// byte (0x80 or above with no lead held) is taken in and gives no phase;
// the following text byte is translated to the display code page.
// The front end accepts whenever the two-entry command queue has room, so
// it keeps taking items while the sequencer works or the output stalls.
// When the block is empty, an accepted item is first written into the
// command queue; its first phase is then loaded into the output register
// and presented on out_o. Register writes are taken on every cycle and must
// only arrive while the block is idle.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_cyrillic_top import clnw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  clnw_in_if.sink    in_i,
  clnw_out_if.source out_o,
  clnw_cfg_if.sink   cfg_i
);

  cfg_t cfg_q;
  cmd_t push_cmd;
  cmd_t head;
  logic fifo_push;
  logic fifo_full;
  logic fifo_pop;
  logic fifo_empty;

  // Register file: always ready, one register per transfer.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_RS_SETUP:  cfg_q.rs_setup   <= cfg_i.data[ShortW-1:0];
        CFG_EN_SETUP:  cfg_q.en_setup   <= cfg_i.data[ShortW-1:0];
        CFG_DATA:      cfg_q.data       <= cfg_i.data[ShortW-1:0];
        CFG_HOLD:      cfg_q.hold       <= cfg_i.data[ShortW-1:0];
        CFG_CTRL_XTRA: cfg_q.ctrl_extra <= cfg_i.data[ExtraW-1:0];
        default: begin
          // Drop writes to unmapped indexes.
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  // Front end: classify, hold lead bytes, translate text.
  clnw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (fifo_push),
    .cmd_o  (push_cmd),
    .full_i (fifo_full)
  );

  // Decouple the front end from the sequencer.
  clnw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .cmd_i   (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .head_o  (head),
    .empty_o (fifo_empty)
  );

  // Back end: one pin phase per cycle into the output register, unless out_o stalls.
  clnw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .head_i  (head),
    .empty_i (fifo_empty),
    .pop_o   (fifo_pop),
    .out_o   (out_o)
  );

  // Never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_push && fifo_full))
    else $error("command queue overflow");

  // Never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_pop && fifo_empty))
    else $error("command queue underflow");

  // The final phase of an item always has enable low.
  a_last_enable_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> !out_o.enable)
    else $error("last phase with enable high");

  // A pop closes an item, so the phase loaded with it is marked last.
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |=> (out_o.valid && out_o.last))
    else $error("queue pop without last phase");

endmodule

>>> rtl/core/clnw_front.sv
// ----------------------------------------------------------------------------
// clnw_front
// Accept input items, track held UTF-8 lead bytes, translate text and
// queue write commands.
// ----------------------------------------------------------------------------
module clnw_front import clnw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  clnw_in_if.sink         in_i,
  output logic            push_o,
  output cmd_t            cmd_o,
  input  logic            full_i
);

  logic  lead_pending_q, lead_pending_d;
  lead_e lead_kind_q, lead_kind_d;
  logic  accept;
  logic  want_push;

  assign in_i.ready = ~full_i;
  assign accept     = in_i.valid & in_i.ready;
  assign push_o     = accept & want_push;

  always_comb begin
    lead_pending_d = lead_pending_q;
    lead_kind_d    = lead_kind_q;
    want_push      = 1'b1;
    cmd_o.rs       = 1'b1;
    cmd_o.single   = 1'b0;
    cmd_o.value    = in_i.byte_value;
    unique case (action_e'(in_i.action))
      ACT_CTRL_BYTE: begin
        cmd_o.rs = 1'b0;
      end
      ACT_DATA_BYTE: begin
        cmd_o.rs = 1'b1;
      end
      ACT_CTRL_NIBBLE: begin
        cmd_o.rs     = 1'b0;
        cmd_o.single = 1'b1;
        cmd_o.value  = {4'h0, in_i.byte_value[NibbleW-1:0]};
      end
      ACT_TEXT: begin
        if (lead_pending_q) begin
          cmd_o.value    = cyr_translate(lead_kind_q, in_i.byte_value);
          lead_pending_d = 1'b0;
          lead_kind_d    = LEAD_OTHER;
        end else if (in_i.byte_value[ByteW-1]) begin
          // Hold the lead byte; it writes nothing by itself.
          want_push      = 1'b0;
          lead_pending_d = 1'b1;
          lead_kind_d    = lead_kind(in_i.byte_value);
        end
      end
      default: begin
        want_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pending_q <= 1'b0;
      lead_kind_q    <= LEAD_OTHER;
    end else if (accept) begin
      lead_pending_q <= lead_pending_d;
      lead_kind_q    <= lead_kind_d;
    end
  end

endmodule

>>> rtl/core/clnw_fifo.sv
// ----------------------------------------------------------------------------
// clnw_fifo
// Two-entry command queue between the front end and the phase sequencer.
// ----------------------------------------------------------------------------
module clnw_fifo import clnw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic empty_o
);

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign empty_o = (count_q == 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/clnw_back.sv
// ----------------------------------------------------------------------------
// clnw_back
// Phase sequencer: turn each queued command into pin phases, one per cycle
// while the output is not stalled, through a registered output stage.
// ----------------------------------------------------------------------------
module clnw_back import clnw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  cmd_t       head_i,
  input  logic       empty_i,
  output logic       pop_o,
  clnw_out_if.source out_o
);

  logic [2:0]         phase_q;
  logic [2:0]         eff;
  phase_e             step;
  logic               load;
  logic               is_last;
  logic               out_valid_q;
  logic               rs_q, en_q, last_q;
  logic [NibbleW-1:0] nib_q;
  logic [WaitW-1:0]   wait_q;
  logic               en_d;
  logic [NibbleW-1:0] nib_d;
  logic [WaitW-1:0]   wait_d;

  // A single nibble starts at the low-nibble half of the sequence.
  assign eff     = phase_q | {head_i.single, 2'b00};
  assign step    = phase_e'(eff[1:0]);
  assign is_last = (eff == 3'd7);
  assign load    = ~empty_i & (~out_valid_q | out_o.ready);
  assign pop_o   = load & is_last;

  always_comb begin
    en_d   = 1'b0;
    nib_d  = '0;
    wait_d = '0;
    unique case (step)
      PH_RS: begin
        wait_d = WaitW'(cfg_i.rs_setup);
      end
      PH_EN: begin
        en_d   = 1'b1;
        wait_d = WaitW'(cfg_i.en_setup);
      end
      PH_DATA: begin
        en_d   = 1'b1;
        nib_d  = eff[2] ? head_i.value[3:0] : head_i.value[7:4];
        wait_d = WaitW'(cfg_i.data);
      end
      PH_HOLD: begin
        nib_d  = eff[2] ? head_i.value[3:0] : head_i.value[7:4];
        wait_d = WaitW'(cfg_i.hold)
               + (head_i.rs ? '0 : WaitW'(cfg_i.ctrl_extra));
      end
      default: begin
        wait_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) phase_q <= is_last ? 3'd0 : phase_q + 3'd1;
      if (load) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rs_q   <= head_i.rs;
      en_q   <= en_d;
      nib_q  <= nib_d;
      wait_q <= wait_d;
      last_q <= is_last;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.reg_select = rs_q;
  assign out_o.enable     = en_q;
  assign out_o.nibble     = nib_q;
  assign out_o.wait_units = wait_q;
  assign out_o.last       = last_q;

endmodule

>>> sim/char_lcd_nibble_writer_cyrillic_top_test.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_cyrillic_top_test
// Self-checking bench for the character LCD nibble writer.
// ----------------------------------------------------------------------------
// Drives control bytes, data bytes, single control nibbles and UTF-8 text
// (lead and trail pairs, stray bytes and broken pairs) into the writer under
// several wait settings. A scoreboard predicts the pin phases of each
// accepted transfer: code-page translation, nibble split and wait counts.
// Each output transfer is compared field by field against the oldest
// predicted phase. Both sides idle in random bursts, except in the last
// part of the run.
// ----------------------------------------------------------------------------
module char_lcd_nibble_writer_cyrillic_top_test import clnw_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // One predicted or observed pin phase.
  typedef struct packed {
    logic               rs;
    logic               en;
    logic [NibbleW-1:0] nib;
    logic [WaitW-1:0]   wt;
    logic               fin;
  } pin_t;

  // Register index the block has no register for; a write there is dropped.
  localparam logic [CfgIdxW-1:0] CfgNoReg  = '1;
  localparam int unsigned        CycleCap  = 400_000;
  localparam int unsigned        TailWait  = 16;
  localparam int unsigned        QuietWait = 8;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the wait registers and the held lead
  // byte, turns each accepted input transfer into pin phases, and checks the
  // output transfers against them in order.
  // --------------------------------------------------------------------------
  class pin_phase_board;
    pin_t              due_pins[$];
    logic [ShortW-1:0] rs_setup, en_setup, data_len, hold_len;
    logic [ExtraW-1:0] ctrl_extra;
    bit                lead_held;
    lead_e             held_kind;
    int unsigned       mismatches, pins_checked, items_taken, leads_taken;

    function new();
      rs_setup   = CfgReset.rs_setup;
      en_setup   = CfgReset.en_setup;
      data_len   = CfgReset.data;
      hold_len   = CfgReset.hold;
      ctrl_extra = CfgReset.ctrl_extra;
      lead_held  = 1'b0;
      held_kind  = LEAD_OTHER;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] v);
      case (idx)
        CFG_RS_SETUP:  rs_setup   = v[ShortW-1:0];
        CFG_EN_SETUP:  en_setup   = v[ShortW-1:0];
        CFG_DATA:      data_len   = v[ShortW-1:0];
        CFG_HOLD:      hold_len   = v[ShortW-1:0];
        CFG_CTRL_XTRA: ctrl_extra = v[ExtraW-1:0];
        default: ;
      endcase
    endfunction

    // Four phases per nibble; control nibbles stretch the hold phase.
    function void push_nibble(bit rs, logic [NibbleW-1:0] nib, bit fin);
      logic [WaitW-1:0] hold_total;
      hold_total = WaitW'(hold_len) + (rs ? '0 : WaitW'(ctrl_extra));
      due_pins.push_back(pin_t'{rs, 1'b0, '0,  WaitW'(rs_setup), 1'b0});
      due_pins.push_back(pin_t'{rs, 1'b1, '0,  WaitW'(en_setup), 1'b0});
      due_pins.push_back(pin_t'{rs, 1'b1, nib, WaitW'(data_len), 1'b0});
      due_pins.push_back(pin_t'{rs, 1'b0, nib, hold_total,       fin});
    endfunction

    function void push_byte(bit rs, logic [ByteW-1:0] b);
      push_nibble(rs, b[7:4], 1'b0);
      push_nibble(rs, b[3:0], 1'b1);
    endfunction

    function lead_e classify_lead(logic [ByteW-1:0] b);
      case (b)
        LeadD0:  return LEAD_D0;
        LeadD1:  return LEAD_D1;
        LeadC2:  return LEAD_C2;
        default: return LEAD_OTHER;
      endcase
    endfunction

    // Trail byte to display code: ROM lookup when inside the table, else the
    // byte itself; the io letters and the degree sign override.
    function logic [ByteW-1:0] code_page(lead_e k, logic [ByteW-1:0] b);
      int          shift;
      int          idx;
      logic [ByteW-1:0] code;
      shift = 0;
      if (k == LEAD_D0) shift = int'(OffsetD0);
      else if (k == LEAD_D1) shift = int'(OffsetD1);
      idx  = int'(b) - shift;
      code = b;
      if (idx >= 0 && idx < 64) code = CyrRom[idx];
      if (k == LEAD_D1 && b == TrailIoSm) code = CodeIoSm;
      if (k == LEAD_D0 && b == TrailIoCap) code = CodeIoCap;
      if (k == LEAD_C2 && b == TrailDeg) code = CodeDeg;
      return code;
    endfunction

    function void add_item(action_e act, logic [ByteW-1:0] b);
      items_taken++;
      case (act)
        ACT_CTRL_BYTE:   push_byte(1'b0, b);
        ACT_DATA_BYTE:   push_byte(1'b1, b);
        ACT_CTRL_NIBBLE: push_nibble(1'b0, b[3:0], 1'b1);
        default: begin
          if (lead_held) begin
            push_byte(1'b1, code_page(held_kind, b));
            lead_held = 1'b0;
            held_kind = LEAD_OTHER;
          end else if (b[7]) begin
            lead_held = 1'b1;
            held_kind = classify_lead(b);
            leads_taken++;
          end else begin
            push_byte(1'b1, b);
          end
        end
      endcase
    endfunction

    function void field_diff(string name, logic [WaitW-1:0] want, logic [WaitW-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_pins(pin_t got);
      pin_t want;
      if (due_pins.size() == 0) begin
        $error("unexpected pin phase: rs %b en %b nibble %h wait %0d last %b",
               got.rs, got.en, got.nib, got.wt, got.fin);
        mismatches++;
        return;
      end
      want = due_pins.pop_front();
      pins_checked++;
      field_diff("reg_select", want.rs,  got.rs);
      field_diff("enable",     want.en,  got.en);
      field_diff("nibble",     want.nib, got.nib);
      field_diff("wait_units", want.wt,  got.wt);
      field_diff("last",       want.fin, got.fin);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  clnw_in_if  in_if ();
  clnw_out_if out_if ();
  clnw_cfg_if cfg_if ();

  char_lcd_nibble_writer_cyrillic_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  pin_phase_board board = new();

  bit          calm_run    = 1'b0;  // no idling on either side once set
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned settings_used = 0;

  always #10 clk_i = ~clk_i;

  // Watchdog: end the run if it hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleCap) begin
      $error("timeout after %0d cycles, %0d pin phases still due",
             cycle_count, board.due_pins.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Output side: hold ready low in random bursts, with open stretches in
  // between; keep it high for the whole calm part.
  always @(posedge clk_i) begin
    if (calm_run) begin
      out_if.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= (stall_left == 1);
    end else if ($urandom_range(0, 6) == 0) begin
      stall_left   <= $urandom_range(1, 11);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Check every output transfer with values as they stood at the edge.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      board.check_pins(pin_t'{out_if.reg_select, out_if.enable, out_if.nibble,
                              out_if.wait_units, out_if.last});
  end

  // Present one item, optionally after an idle burst, and hold it until the
  // transfer happens. Valid stays high into the next item when no gap.
  task automatic send_item(action_e act, logic [ByteW-1:0] b);
    if (!calm_run && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.action     <= act;
    in_if.byte_value <= b;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    board.add_item(act, b);
  endtask

  // Drop valid and wait until every predicted phase has been seen; the quiet
  // wait after that makes sure a lead byte with no output has been taken in.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (board.due_pins.size() != 0) @(posedge clk_i);
    repeat (QuietWait) @(posedge clk_i);
  endtask

  // Write all five wait registers back to back, plus one write to an index
  // with no register behind it. Only call while the block is idle.
  task automatic apply_setting(logic [CfgDataW-1:0] rs_v, logic [CfgDataW-1:0] en_v,
                               logic [CfgDataW-1:0] dt_v, logic [CfgDataW-1:0] hd_v,
                               logic [CfgDataW-1:0] ex_v);
    logic [CfgIdxW-1:0]  idx [6];
    logic [CfgDataW-1:0] val [6];
    idx = '{CFG_RS_SETUP, CFG_EN_SETUP, CFG_DATA, CFG_HOLD, CFG_CTRL_XTRA, CfgNoReg};
    val = '{rs_v, en_v, dt_v, hd_v, ex_v, CfgDataW'($urandom)};
    for (int i = 0; i < 6; i++) begin
      cfg_if.valid <= 1'b1;
      cfg_if.index <= idx[i];
      cfg_if.data  <= val[i];
      do @(posedge clk_i); while (cfg_if.ready !== 1'b1);
      board.set_reg(idx[i], val[i]);
    end
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  // Trail byte for a given lead: mostly inside the code-page table, some
  // special letters, the rest anything at all.
  function automatic logic [ByteW-1:0] pick_trail(logic [ByteW-1:0] lead);
    int unsigned shift;
    int unsigned r;
    shift = (lead == LeadD0) ? OffsetD0 : (lead == LeadD1) ? OffsetD1 : 0;
    r = $urandom_range(0, 99);
    if (r < 55) return ByteW'(shift + $urandom_range(0, 63));
    if (r < 70) begin
      case (lead)
        LeadD0:  return TrailIoCap;
        LeadD1:  return TrailIoSm;
        LeadC2:  return TrailDeg;
        default: return ByteW'($urandom);
      endcase
    end
    return ByteW'($urandom);
  endfunction

  // Random mix: mostly well-formed text pairs, some broken by a control or
  // data byte in the middle, plus stray text bytes and plain writes.
  task automatic run_random(int unsigned count);
    int unsigned      sent;
    int unsigned      pick;
    logic [ByteW-1:0] lead;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0:       lead = LeadD0;
          1:       lead = LeadD1;
          2:       lead = LeadC2;
          default: lead = ByteW'($urandom_range(8'h80, 8'hff));
        endcase
        send_item(ACT_TEXT, lead);
        if ($urandom_range(0, 9) == 0) begin
          send_item($urandom_range(0, 1) ? ACT_DATA_BYTE : ACT_CTRL_BYTE, ByteW'($urandom));
          sent++;
        end
        send_item(ACT_TEXT, pick_trail(lead));
        sent += 2;
      end else begin
        if (pick < 55)      send_item(ACT_TEXT, ByteW'($urandom));
        else if (pick < 70) send_item(ACT_CTRL_BYTE, ByteW'($urandom));
        else if (pick < 85) send_item(ACT_DATA_BYTE, ByteW'($urandom));
        else                send_item(ACT_CTRL_NIBBLE, ByteW'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni            = 1'b0;
    in_if.valid       = 1'b0;
    in_if.action      = ACT_CTRL_BYTE;
    in_if.byte_value  = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = CFG_RS_SETUP;
    cfg_if.data       = '0;
    out_if.ready      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part under the reset waits: field extremes, every action,
    // each special lead and trail, and a lead held across other writes.
    send_item(ACT_CTRL_BYTE,   8'h00);
    send_item(ACT_CTRL_BYTE,   8'hff);
    send_item(ACT_DATA_BYTE,   8'ha5);
    send_item(ACT_DATA_BYTE,   8'h5a);
    send_item(ACT_CTRL_NIBBLE, 8'hff);       // upper bits must be ignored
    send_item(ACT_TEXT,        8'h41);       // plain ASCII text
    send_item(ACT_TEXT, LeadD0); send_item(ACT_TEXT, TrailIoCap);
    send_item(ACT_TEXT, LeadD1); send_item(ACT_TEXT, TrailIoSm);
    send_item(ACT_TEXT, LeadC2); send_item(ACT_TEXT, TrailDeg);
    send_item(ACT_TEXT, LeadD0); send_item(ACT_TEXT, OffsetD0);       // first entry
    send_item(ACT_TEXT, LeadD1); send_item(ACT_TEXT, 8'h8f);          // last entry
    send_item(ACT_TEXT, LeadD1); send_item(ACT_TEXT, 8'h40);          // below the table
    send_item(ACT_TEXT, 8'he2);  send_item(ACT_TEXT, 8'h85);          // other lead, past table
    send_item(ACT_TEXT, LeadD0);                                      // held across writes
    send_item(ACT_CTRL_BYTE,   8'h01);
    send_item(ACT_CTRL_NIBBLE, 8'h0a);
    send_item(ACT_TEXT,        8'hff);       // trail, outside the table
    send_item(ACT_TEXT,        8'hc2);
    send_item(ACT_TEXT,        8'h10);       // degree lead, plain table entry

    // Extremes of the wait registers, then two random settings; the last
    // one runs without idling on either side.
    settle();
    apply_setting('0, '0, '0, '0, '0);
    run_random(30);

    settle();
    apply_setting('1, '1, '1, '1, '1);
    run_random(30);

    settle();
    apply_setting(CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom),
                  CfgDataW'($urandom), CfgDataW'($urandom));
    run_random(40);

    settle();
    calm_run = 1'b1;
    apply_setting(CfgDataW'($urandom_range(0, 15)), CfgDataW'($urandom_range(0, 15)),
                  CfgDataW'($urandom), CfgDataW'($urandom), CfgDataW'($urandom));
    run_random(30);

    settle();
    repeat (TailWait) @(posedge clk_i);

    if (board.due_pins.size() != 0) begin
      $error("%0d predicted pin phases never arrived", board.due_pins.size());
      board.mismatches++;
    end

    $display("Run summary: %0d input items (%0d held as text lead bytes) under %0d settings",
             board.items_taken, board.leads_taken, settings_used + 1);
    $display("Run summary: %0d pin phases compared, %0d mismatches",
             board.pins_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
